// ===== hw/rtl/wfsp_pkg.sv =====
`default_nettype none
package wfsp_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 4095;
	localparam int unsigned POS_W           = 12;

	localparam logic [7:0]       TYPE_MASK       = 8'h0C;
	localparam logic [7:0]       SUBTYPE_MASK    = 8'hF0;
	localparam logic [POS_W-1:0] BEACON_IE_START = POS_W'(36);
	localparam logic [POS_W-1:0] PROBE_IE_START  = POS_W'(24);
	localparam logic [POS_W-1:0] ADDR_FIRST      = POS_W'(10);
	localparam logic [POS_W-1:0] ADDR_LAST       = POS_W'(15);
	localparam logic [POS_W-1:0] SHORT_LEN       = POS_W'(16);
	localparam logic [1:0]       FTYPE_MGMT      = 2'd0;
	localparam logic [3:0]       SUBTYPE_BEACON  = 4'd8;
	localparam logic [3:0]       SUBTYPE_PROBE   = 4'd4;
	localparam logic [7:0]       EID_SSID        = 8'd0;
	localparam logic             KIND_SSID       = 1'b0;
	localparam logic             KIND_SUMMARY    = 1'b1;

	// result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = 2;
	localparam int unsigned RES_CNT_W = 3;

	// element walk phase
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ID   = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]        frame_byte;
		logic              first_byte;
		logic [11:0]       frame_length;
		logic signed [7:0] signal_strength;
		logic [3:0]        radio_channel;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        ssid_byte;
		logic [1:0]        frame_type;
		logic [3:0]        frame_subtype;
		logic [47:0]       source_address;
		logic signed [7:0] rssi_out;
		logic [3:0]        channel_out;
		logic [7:0]        ssid_length;
		logic              ssid_present;
		logic              short_frame;
		logic              last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wfsp_parse.sv =====
`default_nettype none
module wfsp_parse import wfsp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire in_item_t  item,
	output      res_pair_t results
);

	logic [POS_W-1:0] pos_q, len_q, start_q;
	logic [1:0]       type_q;
	logic [3:0]       sub_q;
	logic [47:0]      addr_q;
	logic [7:0]       rssi_q;
	logic [3:0]       chan_q;
	phase_t           phase_q;
	logic             is_ssid_q, found_q, active_q;
	logic [7:0]       rem_q, count_q;

	logic [POS_W-1:0] pos_n, len_n, start_n, p;
	logic [1:0]       type_n;
	logic [3:0]       sub_n;
	logic [47:0]      addr_n;
	logic [7:0]       rssi_n;
	logic [3:0]       chan_n;
	phase_t           phase_n;
	logic             is_ssid_n, found_n, active_n;
	logic [7:0]       rem_n, count_n, b, tmask, smask;
	logic [POS_W:0]   need_w;
	logic             emit_ssid, emit_sum, is_short;
	res_t             ssid_r, sum_r;

	assign b     = item.frame_byte;
	assign tmask = b & TYPE_MASK;
	assign smask = b & SUBTYPE_MASK;

	always_comb begin
		pos_n     = pos_q;
		len_n     = len_q;
		start_n   = start_q;
		type_n    = type_q;
		sub_n     = sub_q;
		addr_n    = addr_q;
		rssi_n    = rssi_q;
		chan_n    = chan_q;
		phase_n   = phase_q;
		is_ssid_n = is_ssid_q;
		found_n   = found_q;
		active_n  = active_q;
		rem_n     = rem_q;
		count_n   = count_q;
		p         = pos_q;
		need_w    = '0;
		emit_ssid = 1'b0;
		emit_sum  = 1'b0;

		// open a new frame: capture side info and drop any open one
		if (item.first_byte) begin
			if (32'(item.frame_length) > MAX_FRAME_BYTES) begin
				len_n = POS_W'(MAX_FRAME_BYTES);
			end else begin
				len_n = POS_W'(item.frame_length);
			end
			rssi_n    = item.signal_strength;
			chan_n    = item.radio_channel;
			p         = '0;
			addr_n    = '0;
			found_n   = 1'b0;
			count_n   = '0;
			is_ssid_n = 1'b0;
			rem_n     = '0;
			phase_n   = PH_IDLE;
			start_n   = '0;
			active_n  = 1'b1;
			type_n    = tmask[3:2];
			sub_n     = smask[7:4];
			if (type_n == FTYPE_MGMT &&
			    (sub_n == SUBTYPE_BEACON || sub_n == SUBTYPE_PROBE)) begin
				start_n = (sub_n == SUBTYPE_BEACON) ? BEACON_IE_START : PROBE_IE_START;
				phase_n = PH_ID;
			end
		end

		if (item.first_byte || active_q) begin
			if (p >= ADDR_FIRST && p <= ADDR_LAST) begin
				addr_n = {addr_n[39:0], b};
			end

			case (phase_n)
				PH_ID: begin
					if (p == start_n) begin
						is_ssid_n = (b == EID_SSID);
						phase_n   = PH_LEN;
					end
				end
				PH_LEN: begin
					need_w = {1'b0, start_n} + (POS_W+1)'(2) + (POS_W+1)'(b);
					if (need_w > {1'b0, len_n}) begin
						phase_n = PH_IDLE;
					end else if (is_ssid_n) begin
						found_n = 1'b1;
						count_n = b;
						rem_n   = b;
						phase_n = (b != 8'd0) ? PH_BODY : PH_IDLE;
					end else if (b == 8'd0) begin
						start_n = start_n + POS_W'(2);
						phase_n = PH_ID;
					end else begin
						rem_n   = b;
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					rem_n     = rem_n - 8'd1;
					emit_ssid = is_ssid_n;
					if (rem_n == 8'd0) begin
						if (is_ssid_n) begin
							phase_n = PH_IDLE;
						end else begin
							start_n = p + POS_W'(1);
							phase_n = PH_ID;
						end
					end
				end
				default: begin
				end
			endcase

			if ({1'b0, p} + (POS_W+1)'(1) >= {1'b0, len_n}) begin
				emit_sum = 1'b1;
				active_n = 1'b0;
				phase_n  = PH_IDLE;
			end

			pos_n = p + POS_W'(1);
		end
	end

	assign is_short = len_n < SHORT_LEN;

	always_comb begin
		ssid_r             = '0;
		ssid_r.kind        = KIND_SSID;
		ssid_r.ssid_byte   = b;
		ssid_r.last_of_run = !emit_sum;

		sum_r                = '0;
		sum_r.kind           = KIND_SUMMARY;
		sum_r.frame_type     = type_n;
		sum_r.frame_subtype  = sub_n;
		sum_r.source_address = is_short ? 48'd0 : addr_n;
		sum_r.rssi_out       = rssi_n;
		sum_r.channel_out    = chan_n;
		sum_r.ssid_length    = found_n ? count_n : 8'd0;
		sum_r.ssid_present   = found_n && (count_n != 8'd0);
		sum_r.short_frame    = is_short;
		sum_r.last_of_run    = 1'b1;

		results       = '0;
		results.count = {1'b0, emit_ssid} + {1'b0, emit_sum};
		results.r0    = emit_ssid ? ssid_r : sum_r;
		results.r1    = sum_r;
		if (!advance) begin
			results.count = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			start_q   <= '0;
			type_q    <= '0;
			sub_q     <= '0;
			addr_q    <= '0;
			rssi_q    <= '0;
			chan_q    <= '0;
			phase_q   <= PH_IDLE;
			is_ssid_q <= 1'b0;
			found_q   <= 1'b0;
			active_q  <= 1'b0;
			rem_q     <= '0;
			count_q   <= '0;
		end else if (advance) begin
			pos_q     <= pos_n;
			len_q     <= len_n;
			start_q   <= start_n;
			type_q    <= type_n;
			sub_q     <= sub_n;
			addr_q    <= addr_n;
			rssi_q    <= rssi_n;
			chan_q    <= chan_n;
			phase_q   <= phase_n;
			is_ssid_q <= is_ssid_n;
			found_q   <= found_n;
			active_q  <= active_n;
			rem_q     <= rem_n;
			count_q   <= count_n;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wfsp_res_fifo.sv =====
`default_nettype none
module wfsp_res_fifo import wfsp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_pair_t push,
	output      logic      room2,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      res_t      out_res
);

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q, rd_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for a full pair of results, so a push never overflows the queue
	assign room2     = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + RES_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(push.count);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wlan_frame_ssid_parser_core.sv =====
// 802.11 frame SSID parser.
// Input channel s_*: one received frame byte per request. s_tuser flags byte 0
// of a frame; length, RSSI and channel in s_tdata are sampled with that byte.
// Output channel m_*: SSID bytes of the first fitting SSID element as they
// arrive (m_tuser = 0), then an end-of-frame summary (m_tuser = 1) on the
// frame's last byte. m_tlast marks the final result caused by one input byte.
// Path: an accepted byte sits in the input register, is parsed and queued
// once the queue has room for a pair, and then shows on m_tvalid.
// Throughput: one byte per cycle while the queue can take a pair; the parse
// is one short pass from the input register into a four-entry result queue.
// A byte with two results (last SSID byte on last frame byte) fills two entries.
// Stall: when m_tready is low the queue fills; s_tready drops once the queue
// can no longer take a full pair of results, and the held byte waits.
// Reset: empties the queue and the input register and clears all parse state;
// no frame is open, and bytes without a first-byte flag are consumed silently.
`default_nettype none
module wlan_frame_ssid_parser_core import wfsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// frame_byte[7:0], frame_length[19:8], signal_strength[27:20], radio_channel[31:28]
	input  wire logic [31:0] s_tdata,
	// first_byte
	input  wire logic        s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// ssid_byte[7:0], frame_type[9:8], frame_subtype[13:10], source_address[61:14],
	// rssi_out[69:62], channel_out[73:70], ssid_length[81:74], ssid_present[82],
	// short_frame[83], zero[87:84]
	output      logic [87:0] m_tdata,
	// kind
	output      logic        m_tuser,
	// last_of_run
	output      logic        m_tlast
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      room2;
	logic      advance;
	res_pair_t results;
	res_t      out_res;

	// the held byte moves into the parser whenever the queue can take a pair
	assign advance  = valid_s1 && room2;
	assign s_tready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.frame_byte      <= s_tdata[7:0];
			item_s1.frame_length    <= s_tdata[19:8];
			item_s1.signal_strength <= s_tdata[27:20];
			item_s1.radio_channel   <= s_tdata[31:28];
			item_s1.first_byte      <= s_tuser;
		end
	end

	wfsp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.results (results)
	);

	wfsp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (results),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// pack the result fields, listed from the highest bits down
	assign m_tdata = {4'd0,
	                  out_res.short_frame,
	                  out_res.ssid_present,
	                  out_res.ssid_length,
	                  out_res.channel_out,
	                  out_res.rssi_out,
	                  out_res.source_address,
	                  out_res.frame_subtype,
	                  out_res.frame_type,
	                  out_res.ssid_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_of_run;

endmodule
`default_nettype wire
